// ===== hdl/tlas_pkg.sv =====
package tlas_pkg;

  localparam int TIME_W = 16;
  localparam int COST_W = 24;
  localparam int CNT_W  = 7;
  localparam int LINE_W = 2;
  localparam int CFG_W  = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // line codes as reported on the result channel
  localparam logic [LINE_W-1:0] LINE1 = 2'd1;
  localparam logic [LINE_W-1:0] LINE2 = 2'd2;

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_ENTRY1 = 2'd0;
  localparam logic [CFG_W-1:0] CFG_ENTRY2 = 2'd1;
  localparam logic [CFG_W-1:0] CFG_EXIT1  = 2'd2;
  localparam logic [CFG_W-1:0] CFG_EXIT2  = 2'd3;

  // choice bits of one station, written into the path memory
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] station;
    logic             cf1;   // 1: best path into line 1 came from line 2
    logic             cf2;   // 1: best path into line 2 came from line 2
  } path_wr_t;

  // one finished forward pass
  typedef struct packed {
    logic [COST_W-1:0] cost1;
    logic [COST_W-1:0] cost2;
    logic [CNT_W-1:0]  count;
  } job_t;

  typedef struct packed {
    logic full;
    logic bank;
  } q_tail_t;

  typedef struct packed {
    logic valid;
    logic bank;
    job_t job;
  } q_head_t;

  // saturating a + b + c, equal to two chained saturating adds
  function automatic logic [COST_W-1:0] sat_add3(input logic [COST_W-1:0] a,
                                                 input logic [TIME_W-1:0] b,
                                                 input logic [TIME_W-1:0] c);
    logic [COST_W+1:0] s;
    s = {2'b00, a} + {{(COST_W+2-TIME_W){1'b0}}, b}
      + {{(COST_W+2-TIME_W){1'b0}}, c};
    return (s > {2'b00, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

// ===== hdl/tlas_front.sv =====
module tlas_front
  import tlas_pkg::*;
#(
  parameter int MAX_STATIONS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_work_time_line1,
  input  logic [TIME_W-1:0] in_work_time_line2,
  input  logic [TIME_W-1:0] in_move_from_line1,
  input  logic [TIME_W-1:0] in_move_from_line2,
  input  logic              in_final_station,
  input  logic [TIME_W-1:0] entry1,
  input  logic [TIME_W-1:0] entry2,
  input  q_tail_t           tail,
  output logic              push,
  output job_t              push_job,
  output path_wr_t          wr
);

  logic [COST_W-1:0] best1_r, best1_nxt;
  logic [COST_W-1:0] best2_r, best2_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              accept;
  logic              last;
  logic [CNT_W-1:0]  cnt_inc;
  logic [COST_W-1:0] stay1, cross1, stay2, cross2;
  logic [COST_W-1:0] n1, n2;
  logic              cf1, cf2;

  assign in_stall = tail.full;
  assign accept   = in_valid && !tail.full;
  assign cnt_inc  = count_r + 1'b1;
  assign last     = in_final_station || (cnt_inc == CNT_W'(MAX_STATIONS));

  always_comb begin
    stay1  = sat_add3(best1_r, in_work_time_line1, '0);
    cross1 = sat_add3(best2_r, in_move_from_line2, in_work_time_line1);
    stay2  = sat_add3(best2_r, in_work_time_line2, '0);
    cross2 = sat_add3(best1_r, in_move_from_line1, in_work_time_line2);
    cf1    = !(stay1 <= cross1);
    cf2    = (stay2 <= cross2);
    if (count_r == '0) begin
      n1 = sat_add3({{(COST_W-TIME_W){1'b0}}, entry1}, in_work_time_line1, '0);
      n2 = sat_add3({{(COST_W-TIME_W){1'b0}}, entry2}, in_work_time_line2, '0);
    end else begin
      n1 = cf1 ? cross1 : stay1;
      n2 = cf2 ? stay2 : cross2;
    end
  end

  always_comb begin
    best1_nxt = best1_r;
    best2_nxt = best2_r;
    count_nxt = count_r;
    if (accept) begin
      if (last) begin
        best1_nxt = '0;
        best2_nxt = '0;
        count_nxt = '0;
      end else begin
        best1_nxt = n1;
        best2_nxt = n2;
        count_nxt = cnt_inc;
      end
    end
  end

  assign push           = accept && last;
  assign push_job.cost1 = n1;
  assign push_job.cost2 = n2;
  assign push_job.count = cnt_inc;

  assign wr.en      = accept && (count_r != '0);
  assign wr.bank    = tail.bank;
  assign wr.station = count_r;
  assign wr.cf1     = cf1;
  assign wr.cf2     = cf2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best1_r <= '0;
      best2_r <= '0;
      count_r <= '0;
    end else begin
      best1_r <= best1_nxt;
      best2_r <= best2_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/tlas_job_q.sv =====
module tlas_job_q
  import tlas_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  output q_tail_t tail,
  input  logic    pop,
  output q_head_t head
);

  logic [1:0] valid_r, valid_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  job_t       job_r [2];

  // an entry stays valid until its backtrace is done, so it also owns a memory bank
  assign tail.full  = valid_r[wr_ptr_r];
  assign tail.bank  = wr_ptr_r;
  assign head.valid = valid_r[rd_ptr_r];
  assign head.bank  = rd_ptr_r;
  assign head.job   = job_r[rd_ptr_r];

  always_comb begin
    valid_nxt = valid_r;
    if (pop) valid_nxt[rd_ptr_r] = 1'b0;
    if (push) valid_nxt[wr_ptr_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) job_r[wr_ptr_r] <= push_job;
  end

  a_push_free : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !valid_r[wr_ptr_r])
    else $error("job pushed into a busy entry");

  a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid_r[rd_ptr_r])
    else $error("job popped from an empty entry");

endmodule

// ===== hdl/tlas_back.sv =====
module tlas_back
  import tlas_pkg::*;
#(
  parameter int MAX_STATIONS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TIME_W-1:0] exit1,
  input  logic [TIME_W-1:0] exit2,
  input  path_wr_t          wr,
  input  q_head_t           head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LINE_W-1:0] out_path_line,
  output logic [CNT_W-1:0]  out_path_station,
  output logic [COST_W-1:0] out_total_time,
  output logic              out_path_end
);

  localparam int AW    = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int DEPTH = 2 ** (AW + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COST_W-1:0] total_r, total_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0] out_line_r, out_line_nxt;
  logic [CNT_W-1:0]  out_station_r, out_station_nxt;
  logic [COST_W-1:0] out_total_r, out_total_nxt;
  logic              out_end_r, out_end_nxt;

  // choice bits {cf2, cf1} per bank and station
  logic [1:0]        mem [DEPTH];
  logic [1:0]        rd_data_r;
  logic [AW:0]       rd_addr;
  logic [CNT_W-1:0]  rd_slot;

  logic              out_free;
  logic              emit;
  logic              back_bit;
  logic [COST_W-1:0] e1, e2;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r == ST_RUN) && out_free;
  assign pop      = emit && (j_r == CNT_W'(1));
  assign back_bit = (line_r == LINE2) ? rd_data_r[1] : rd_data_r[0];
  assign e1 = sat_add3(head.job.cost1, exit1, '0);
  assign e2 = sat_add3(head.job.cost2, exit2, '0);
  assign rd_addr = {head.bank, rd_slot[AW-1:0]};

  always_comb begin
    state_nxt       = state_r;
    j_nxt           = j_r;
    line_nxt        = line_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_free ? 1'b0 : out_valid_r;
    out_line_nxt    = out_line_r;
    out_station_nxt = out_station_r;
    out_total_nxt   = out_total_r;
    out_end_nxt     = out_end_r;
    rd_slot         = j_r - CNT_W'(1);
    unique case (state_r)
      ST_IDLE: begin
        // prefetch the choice bits of the last station
        rd_slot = head.job.count - CNT_W'(1);
        if (head.valid) begin
          j_nxt     = head.job.count;
          line_nxt  = (e1 <= e2) ? LINE1 : LINE2;
          total_nxt = (e1 <= e2) ? e1 : e2;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // keep the read on the current station while stalled
        rd_slot = emit ? (j_r - CNT_W'(2)) : (j_r - CNT_W'(1));
        if (emit) begin
          out_valid_nxt   = 1'b1;
          out_line_nxt    = line_r;
          out_station_nxt = j_r;
          out_total_nxt   = total_r;
          out_end_nxt     = (j_r == CNT_W'(1));
          if (j_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt    = j_r - CNT_W'(1);
            line_nxt = back_bit ? LINE2 : LINE1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.bank, wr.station[AW-1:0]}] <= {wr.cf2, wr.cf1};
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r           <= j_nxt;
    line_r        <= line_nxt;
    total_r       <= total_nxt;
    out_line_r    <= out_line_nxt;
    out_station_r <= out_station_nxt;
    out_total_r   <= out_total_nxt;
    out_end_r     <= out_end_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_path_line    = out_line_r;
  assign out_path_station = out_station_r;
  assign out_total_time   = out_total_r;
  assign out_path_end     = out_end_r;

  a_run_holds_job : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> head.valid)
    else $error("backtrace running without a queued job");

  a_pop_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_IDLE)
    else $error("backtrace did not stop after station 1");

  a_out_sane : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_station_r != '0)
                    && (out_line_r == LINE1 || out_line_r == LINE2))
    else $error("result with bad station or line");

endmodule

// ===== hdl/two_line_assembly_schedule_core.sv =====
// two-line assembly schedule
//
// input channel (in_valid / in_stall): one item per station, work times on
// both lines and transfer times from the previous station; in_final_station
// closes the problem, as does the item that reaches MAX_STATIONS stations.
// the forward pass takes one item per clock, so in_stall is low until both
// path memory banks hold problems that are still being traced back.
// result channel (out_valid / out_stall): for a problem of n stations, n
// items from station n down to station 1, each with the chosen line and the
// total time; path_end marks station 1. the first result is registered
// after the job queue and the backtrace state register, then one result per
// cycle while out_stall is low; the backtrace reads one path memory entry
// per cycle. with two banks the next problem runs forward while the
// previous one is traced. out_stall holds the output register and freezes
// the backtrace; the front keeps going until it needs a busy bank.
// configuration (cfg_valid / cfg_ready, always ready): entry and exit times;
// the user must see that they are written only while idle, which the block
// does not enforce. synchronous reset clears the config registers, the
// running costs, the station count and all queued problems.

module two_line_assembly_schedule_core
  import tlas_pkg::*;
#(
  parameter int MAX_STATIONS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_work_time_line1,
  input  logic [TIME_W-1:0] in_work_time_line2,
  input  logic [TIME_W-1:0] in_move_from_line1,
  input  logic [TIME_W-1:0] in_move_from_line2,
  input  logic              in_final_station,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LINE_W-1:0] out_path_line,
  output logic [CNT_W-1:0]  out_path_station,
  output logic [COST_W-1:0] out_total_time,
  output logic              out_path_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0] cfg_data
);

  logic [TIME_W-1:0] entry1_r, entry2_r, exit1_r, exit2_r;

  q_tail_t  tail;
  q_head_t  head;
  logic     push;
  logic     pop;
  job_t     push_job;
  path_wr_t wr;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry1_r <= '0;
      entry2_r <= '0;
      exit1_r  <= '0;
      exit2_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENTRY1: entry1_r <= cfg_data;
        CFG_ENTRY2: entry2_r <= cfg_data;
        CFG_EXIT1:  exit1_r  <= cfg_data;
        CFG_EXIT2:  exit2_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // forward pass: running best costs and choice bits
  tlas_front #(
    .MAX_STATIONS(MAX_STATIONS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_work_time_line1 (in_work_time_line1),
    .in_work_time_line2 (in_work_time_line2),
    .in_move_from_line1 (in_move_from_line1),
    .in_move_from_line2 (in_move_from_line2),
    .in_final_station   (in_final_station),
    .entry1             (entry1_r),
    .entry2             (entry2_r),
    .tail               (tail),
    .push               (push),
    .push_job           (push_job),
    .wr                 (wr)
  );

  // two finished problems at most, one per memory bank
  tlas_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .tail     (tail),
    .pop      (pop),
    .head     (head)
  );

  // exit choice and backtrace through the path memory
  tlas_back #(
    .MAX_STATIONS(MAX_STATIONS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .exit1            (exit1_r),
    .exit2            (exit2_r),
    .wr               (wr),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_path_line    (out_path_line),
    .out_path_station (out_path_station),
    .out_total_time   (out_total_time),
    .out_path_end     (out_path_end)
  );

endmodule
